### sv/opposite_class_nearest_distance_unit_assert.svh
// Assertion macros for the checker file of this block.
`ifndef OPPOSITE_CLASS_NEAREST_DISTANCE_UNIT_ASSERT_SVH
`define OPPOSITE_CLASS_NEAREST_DISTANCE_UNIT_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define OCND_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ocnd assertion failed");

// Antecedent implies consequent in the next cycle.
`define OCND_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ocnd assertion failed");

`endif

### sv/ocnd_pkg.sv
package ocnd_pkg;

  // Fixed field widths of the item interfaces.
  localparam int NODE_BITS   = 10;
  localparam int IN_W_BITS   = 16;
  localparam int CNT_BITS    = 11;
  localparam int OUT_D_BITS  = 26;
  localparam logic [OUT_D_BITS-1:0] DIST_MAX = '1;

  // Default sizes handed to the top level.
  localparam int DEF_NODES       = 1024;
  localparam int DEF_EDGES       = 4096;
  localparam int DEF_WEIGHT_BITS = 16;

  typedef enum logic [1:0] {
    OP_LABEL = 2'd0,
    OP_EDGE  = 2'd1,
    OP_RUN   = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [NODE_BITS-1:0] node;
    logic                 label;
    logic [NODE_BITS-1:0] edge_end;
    logic [IN_W_BITS-1:0] weight;
  } in_item_t;

  typedef struct packed {
    logic [OUT_D_BITS-1:0] distance;
    logic                  unreachable;
    logic                  status;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_SCAN,
    ST_SETTLE,
    ST_EDGE_RD,
    ST_EDGE_CHK,
    ST_EDGE_UPD,
    ST_Q_LBL,
    ST_Q_DST
  } state_t;

endpackage

### sv/ocnd_edge_store.sv
module ocnd_edge_store #(
  parameter int EDGES       = ocnd_pkg::DEF_EDGES,
  parameter int WEIGHT_BITS = ocnd_pkg::DEF_WEIGHT_BITS,
  parameter int EAW         = (EDGES > 1) ? $clog2(EDGES) : 1,
  parameter int ECNT_W      = $clog2(EDGES + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [ocnd_pkg::NODE_BITS-1:0] wr_start,
  input  logic [ocnd_pkg::NODE_BITS-1:0] wr_end,
  input  logic [WEIGHT_BITS-1:0]         wr_weight,
  output logic                           full,
  output logic [ECNT_W-1:0]              count,
  input  logic [EAW-1:0]                 rd_addr,
  output logic [ocnd_pkg::NODE_BITS-1:0] rd_start,
  output logic [ocnd_pkg::NODE_BITS-1:0] rd_end,
  output logic [WEIGHT_BITS-1:0]         rd_weight
);
  import ocnd_pkg::*;

  localparam int ENT_W = 2 * NODE_BITS + WEIGHT_BITS;

  logic [ENT_W-1:0]  mem [EDGES];
  logic [ENT_W-1:0]  rd_q_r;
  logic [ECNT_W-1:0] count_r;
  logic [ECNT_W-1:0] count_nxt;

  assign full  = (32'(count_r) >= EDGES);
  assign count = count_r;

  // Append at the fill count; a transfer into a full store is dropped.
  always_comb begin
    count_nxt = count_r;
    if (wr_en && !full) begin
      count_nxt = count_r + ECNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Edge memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en && !full) begin
      mem[count_r[EAW-1:0]] <= {wr_start, wr_end, wr_weight};
    end
    rd_q_r <= mem[rd_addr];
  end

  assign rd_start  = rd_q_r[ENT_W-1 -: NODE_BITS];
  assign rd_end    = rd_q_r[WEIGHT_BITS +: NODE_BITS];
  assign rd_weight = rd_q_r[WEIGHT_BITS-1:0];

endmodule

### sv/opposite_class_nearest_distance_unit.sv
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid / in_ready   | in_data (ocnd_pkg::in_item_t)
// out     | output    | out_valid / out_ready | out_data (ocnd_pkg::out_item_t)
// cfg     | input     | cfg_valid / cfg_ready | cfg_node_count (11 bits)
//
// Label and edge transfers answer in the next cycle; a query reads the label, then the
// distance. A run does two searches, each a setup of the class table over all NODES
// entries, then per settled node a minimum scan over the n nodes in use, a settle step,
// a check of each stored edge with an update where it relaxes, a step to end the edge
// walk, and a last scan that finds nothing, all set by the single distance read port.
// Reset is synchronous and active low; it clears control state, the edge count and
// sets the node count to NODES.
// The input is stalled while a result waits and out_ready is low, during a query and
// during a run.
module opposite_class_nearest_distance_unit #(
  parameter int NODES       = ocnd_pkg::DEF_NODES,
  parameter int EDGES       = ocnd_pkg::DEF_EDGES,
  parameter int WEIGHT_BITS = ocnd_pkg::DEF_WEIGHT_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ocnd_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ocnd_pkg::out_item_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ocnd_pkg::CNT_BITS-1:0] cfg_node_count
);
  import ocnd_pkg::*;

  localparam int NAW    = $clog2(NODES);
  localparam int CNT_W  = $clog2(NODES + 1);
  localparam int EAW    = (EDGES > 1) ? $clog2(EDGES) : 1;
  localparam int ECNT_W = $clog2(EDGES + 1);
  localparam int DIST_W = NAW + WEIGHT_BITS;
  localparam int ENT_W  = DIST_W + 2;

  // Distance entry: settled flag, unreached flag, path length.
  typedef struct packed {
    logic              settled;
    logic              unreached;
    logic [DIST_W-1:0] plen;
  } dent_t;

  // Configuration register and the count it allows.
  logic [CNT_BITS-1:0] node_count_r;
  logic [CNT_W-1:0]    n_cur;

  assign cfg_ready = 1'b1;
  assign n_cur = (32'(node_count_r) > NODES) ? CNT_W'(NODES) : CNT_W'(node_count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= CNT_BITS'(NODES);
    end else if (cfg_valid) begin
      node_count_r <= cfg_node_count;
    end
  end

  // Control registers.
  state_t            state_r, state_nxt;
  logic              cls_r, cls_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic              pend_r, pend_nxt;
  logic [NAW-1:0]    pidx_r, pidx_nxt;
  logic              found_r, found_nxt;
  logic [NAW-1:0]    best_r, best_nxt;
  logic [DIST_W-1:0] best_dist_r, best_dist_nxt;
  logic [ECNT_W-1:0] eidx_r, eidx_nxt;
  logic [NAW-1:0]    s_r, s_nxt;
  logic [WEIGHT_BITS-1:0] w_r, w_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [NAW-1:0]    qnode_r, qnode_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;

  // Memory ports.
  logic              lab_mem [NODES];
  logic              lab_we;
  logic [NAW-1:0]    lab_waddr, lab_raddr;
  logic              lab_q_r;
  dent_t             dmem [2*NODES];
  logic              d_we;
  logic [NAW:0]      d_waddr, d_raddr;
  dent_t             d_wdata, d_q_r;

  // Edge store ports.
  logic              e_we;
  logic              e_full;
  logic [ECNT_W-1:0] e_count;
  logic [NODE_BITS-1:0] e_start, e_end;
  logic [WEIGHT_BITS-1:0] e_weight;

  logic              in_xfer;
  logic [DIST_W-1:0] nd;
  logic [NAW-1:0]    e_start_idx;

  assign in_xfer   = in_valid && in_ready;
  assign in_ready  = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign nd        = best_dist_r + DIST_W'(w_r);
  assign e_start_idx = NAW'(e_start);

  ocnd_edge_store #(
    .EDGES       (EDGES),
    .WEIGHT_BITS (WEIGHT_BITS),
    .EAW         (EAW),
    .ECNT_W      (ECNT_W)
  ) u_edges (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (e_we),
    .wr_start  (in_data.node),
    .wr_end    (in_data.edge_end),
    .wr_weight (WEIGHT_BITS'(in_data.weight)),
    .full      (e_full),
    .count     (e_count),
    .rd_addr   (eidx_r[EAW-1:0]),
    .rd_start  (e_start),
    .rd_end    (e_end),
    .rd_weight (e_weight)
  );

  // Label memory.
  always_ff @(posedge clk) begin
    if (lab_we) begin
      lab_mem[lab_waddr] <= in_data.label;
    end
    lab_q_r <= lab_mem[lab_raddr];
  end

  // Distance memory, both classes side by side.
  always_ff @(posedge clk) begin
    if (d_we) begin
      dmem[d_waddr] <= d_wdata;
    end
    d_q_r <= dmem[d_raddr];
  end

  // Sequencer: next state, memory accesses and results.
  always_comb begin
    state_nxt     = state_r;
    cls_nxt       = cls_r;
    idx_nxt       = idx_r;
    pend_nxt      = 1'b0;
    pidx_nxt      = pidx_r;
    found_nxt     = found_r;
    best_nxt      = best_r;
    best_dist_nxt = best_dist_r;
    eidx_nxt      = eidx_r;
    s_nxt         = s_r;
    w_nxt         = w_r;
    n_nxt         = n_r;
    qnode_nxt     = qnode_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    lab_we        = 1'b0;
    lab_waddr     = NAW'(in_data.node);
    lab_raddr     = NAW'(in_data.node);
    d_we          = 1'b0;
    d_waddr       = {cls_r, pidx_r};
    d_wdata       = '0;
    d_raddr       = {cls_r, idx_r[NAW-1:0]};
    e_we          = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          out_nxt = '0;
          unique case (in_data.op)
            OP_LABEL: begin
              lab_we = (32'(in_data.node) < NODES);
              out_valid_nxt = 1'b1;
            end
            OP_EDGE: begin
              e_we = 1'b1;
              out_nxt.status = e_full;
              out_valid_nxt = 1'b1;
            end
            OP_RUN: begin
              n_nxt     = n_cur;
              cls_nxt   = 1'b0;
              idx_nxt   = '0;
              state_nxt = ST_INIT;
            end
            OP_QUERY: begin
              if (32'(in_data.node) >= 32'(n_cur)) begin
                out_nxt.unreachable = 1'b1;
                out_valid_nxt = 1'b1;
              end else begin
                qnode_nxt = NAW'(in_data.node);
                state_nxt = ST_Q_LBL;
              end
            end
            default: ;
          endcase
        end
      end

      // Clear the class table; the label read runs one entry ahead of the write.
      ST_INIT: begin
        lab_raddr = idx_r[NAW-1:0];
        if (32'(idx_r) < NODES) begin
          pend_nxt = 1'b1;
          pidx_nxt = idx_r[NAW-1:0];
          idx_nxt  = idx_r + CNT_W'(1);
        end
        if (pend_r) begin
          d_we = 1'b1;
          d_wdata.unreached = !((32'(pidx_r) < 32'(n_r)) && (lab_q_r == cls_r));
        end
        if ((32'(idx_r) >= NODES) && !pend_r) begin
          idx_nxt   = '0;
          found_nxt = 1'b0;
          state_nxt = ST_SCAN;
        end
      end

      // Find the least unsettled reached node, first index on ties.
      ST_SCAN: begin
        if (idx_r < n_r) begin
          pend_nxt = 1'b1;
          pidx_nxt = idx_r[NAW-1:0];
          idx_nxt  = idx_r + CNT_W'(1);
        end
        if (pend_r && !d_q_r.settled && !d_q_r.unreached &&
            (!found_r || (d_q_r.plen < best_dist_r))) begin
          found_nxt     = 1'b1;
          best_nxt      = pidx_r;
          best_dist_nxt = d_q_r.plen;
        end
        if ((idx_r >= n_r) && !pend_r) begin
          if (found_r) begin
            state_nxt = ST_SETTLE;
          end else if (!cls_r) begin
            cls_nxt   = 1'b1;
            idx_nxt   = '0;
            state_nxt = ST_INIT;
          end else begin
            out_nxt       = '0;
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end
      end

      ST_SETTLE: begin
        d_we    = 1'b1;
        d_waddr = {cls_r, best_r};
        d_wdata.settled = 1'b1;
        d_wdata.plen    = best_dist_r;
        eidx_nxt  = '0;
        state_nxt = ST_EDGE_RD;
      end

      // Walk the edge store; relax edges that end at the settled node.
      ST_EDGE_RD: begin
        if (eidx_r < e_count) begin
          state_nxt = ST_EDGE_CHK;
        end else begin
          idx_nxt   = '0;
          found_nxt = 1'b0;
          state_nxt = ST_SCAN;
        end
      end

      ST_EDGE_CHK: begin
        eidx_nxt = eidx_r + ECNT_W'(1);
        d_raddr  = {cls_r, e_start_idx};
        s_nxt    = e_start_idx;
        w_nxt    = e_weight;
        if ((32'(e_end) == 32'(best_r)) && (32'(e_start) < 32'(n_r))) begin
          state_nxt = ST_EDGE_UPD;
        end else begin
          state_nxt = ST_EDGE_RD;
        end
      end

      ST_EDGE_UPD: begin
        if (d_q_r.unreached || (nd < d_q_r.plen)) begin
          d_we    = 1'b1;
          d_waddr = {cls_r, s_r};
          d_wdata.settled = d_q_r.settled;
          d_wdata.plen    = nd;
        end
        state_nxt = ST_EDGE_RD;
      end

      // Query: label first, then the opposite class entry.
      ST_Q_LBL: begin
        d_raddr   = {!lab_q_r, qnode_r};
        state_nxt = ST_Q_DST;
      end

      ST_Q_DST: begin
        out_nxt = '0;
        if (d_q_r.unreached) begin
          out_nxt.unreachable = 1'b1;
        end else if (64'(d_q_r.plen) > 64'(DIST_MAX)) begin
          out_nxt.distance = DIST_MAX;
        end else begin
          out_nxt.distance = OUT_D_BITS'(d_q_r.plen);
        end
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    cls_r       <= cls_nxt;
    idx_r       <= idx_nxt;
    pidx_r      <= pidx_nxt;
    found_r     <= found_nxt;
    best_r      <= best_nxt;
    best_dist_r <= best_dist_nxt;
    eidx_r      <= eidx_nxt;
    s_r         <= s_nxt;
    w_r         <= w_nxt;
    n_r         <= n_nxt;
    qnode_r     <= qnode_nxt;
    out_r       <= out_nxt;
  end

endmodule

### sv/ocnd_checker.sv
`include "opposite_class_nearest_distance_unit_assert.svh"

module ocnd_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input ocnd_pkg::in_item_t            in_data,
  input logic                          out_valid,
  input logic                          out_ready,
  input ocnd_pkg::out_item_t           out_data
);
  import ocnd_pkg::*;

  // A waiting result stays until it is taken.
  `OCND_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

  // A label transfer yields an all-zero result in the next cycle.
  `OCND_ASSERT_NEXT(a_label_result, in_valid && in_ready && in_data.op == OP_LABEL,
                    out_valid && out_data.distance == 0 && !out_data.unreachable)

  // An edge transfer yields a result with no distance in the next cycle.
  `OCND_ASSERT_NEXT(a_edge_result, in_valid && in_ready && in_data.op == OP_EDGE,
                    out_valid && out_data.distance == 0 && !out_data.unreachable)

  // An unreachable answer carries no distance.
  `OCND_ASSERT_NOW(a_unreach_zero, out_valid && out_data.unreachable,
                   out_data.distance == 0 && !out_data.status)

endmodule

bind opposite_class_nearest_distance_unit ocnd_checker u_ocnd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

### verif/opposite_class_nearest_distance_unit_tb.sv
`timescale 1ns / 1ps

module opposite_class_nearest_distance_unit_tb;
  import ocnd_pkg::*;

  localparam int MAX_NODES = 1024;
  localparam int MAX_EDGES = 4096;
  localparam int QUIET_LIMIT = 1500000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 1700;

  // Predicts each result from its own copy of the labels, edges and search tables.
  class opposite_distance_scoreboard;
    bit                    labels[MAX_NODES];
    logic [NODE_BITS-1:0]  edge_from[MAX_EDGES];
    logic [NODE_BITS-1:0]  edge_to[MAX_EDGES];
    logic [IN_W_BITS-1:0]  edge_len[MAX_EDGES];
    int unsigned           edges_loaded;
    longint unsigned       reach_len[2][MAX_NODES];
    bit                    unreached[2][MAX_NODES];
    int unsigned           node_count;
    out_item_t             expected_q[$];
    int                    errors;

    function new();
      edges_loaded = 0;
      node_count = MAX_NODES;
      errors = 0;
    endfunction

    function int unsigned nodes_in_use();
      return (node_count > MAX_NODES) ? MAX_NODES : node_count;
    endfunction

    // Multi-source search from every node of one class over the reversed edges.
    function void search_from_class(int cls);
      bit              done[MAX_NODES];
      int unsigned     n;
      int unsigned     best;
      bit              found;
      longint unsigned cand;
      int unsigned     src;
      n = nodes_in_use();
      for (int i = 0; i < MAX_NODES; i++) begin
        done[i] = 0;
        reach_len[cls][i] = 0;
        unreached[cls][i] = !(i < n && labels[i] == cls);
      end
      while (1) begin
        found = 0;
        best = 0;
        for (int i = 0; i < n; i++) begin
          if (done[i] || unreached[cls][i]) continue;
          if (!found || reach_len[cls][i] < reach_len[cls][best]) begin
            best = i;
            found = 1;
          end
        end
        if (!found) break;
        done[best] = 1;
        for (int k = 0; k < edges_loaded; k++) begin
          src = edge_from[k];
          if (edge_to[k] != best || src >= n) continue;
          cand = reach_len[cls][best] + edge_len[k];
          if (unreached[cls][src] || cand < reach_len[cls][src]) begin
            reach_len[cls][src] = cand;
            unreached[cls][src] = 0;
          end
        end
      end
    endfunction

    // Notes an accepted input and queues the result it must cause.
    function void note_input(in_item_t it);
      out_item_t r;
      int        other;
      r = '0;
      case (it.op)
        OP_LABEL: labels[it.node] = it.label;
        OP_EDGE: begin
          if (edges_loaded < MAX_EDGES) begin
            edge_from[edges_loaded] = it.node;
            edge_to[edges_loaded] = it.edge_end;
            edge_len[edges_loaded] = it.weight;
            edges_loaded++;
          end else begin
            r.status = 1'b1;
          end
        end
        OP_RUN: begin
          search_from_class(0);
          search_from_class(1);
        end
        default: begin
          if (it.node >= nodes_in_use()) begin
            r.unreachable = 1'b1;
          end else begin
            other = labels[it.node] ? 0 : 1;
            if (unreached[other][it.node]) begin
              r.unreachable = 1'b1;
            end else if (reach_len[other][it.node] > DIST_MAX) begin
              r.distance = DIST_MAX;
            end else begin
              r.distance = reach_len[other][it.node][OUT_D_BITS-1:0];
            end
          end
        end
      endcase
      expected_q = {expected_q, r};
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    // Compares one result transfer with the oldest expectation.
    task check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        report("result transfer with no expectation pending");
      end else begin
        want = expected_q.pop_front();
        if (got.distance !== want.distance)
          report($sformatf("distance got %0d want %0d", got.distance, want.distance));
        if (got.unreachable !== want.unreachable)
          report($sformatf("unreachable got %0b want %0b", got.unreachable, want.unreachable));
        if (got.status !== want.status)
          report($sformatf("status got %0b want %0b", got.status, want.status));
      end
    endtask
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_ready;
  out_item_t           out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CNT_BITS-1:0] cfg_node_count;

  opposite_distance_scoreboard sb;
  bit quiet;
  bit gaps_on;
  int stall_left;
  int quiet_cycles;

  opposite_class_nearest_distance_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_node_count(cfg_node_count)
  );

  always #5 clk = ~clk;

  // Result side: checks each transfer and stalls in random bursts.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_result(out_data);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 24) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no transfer on any channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("** opposite_class_nearest_distance_unit: FAILED **");
        $finish;
      end
    end
  end

  // Sends one item, with an optional idle burst before it.
  task send_item(in_item_t it);
    if (!quiet && gaps_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
  endtask

  function in_item_t make_item(op_t op, int node, int lbl, int end_node, int w);
    in_item_t it;
    it.op = op;
    it.node = NODE_BITS'(node);
    it.label = 1'(lbl);
    it.edge_end = NODE_BITS'(end_node);
    it.weight = IN_W_BITS'(w);
    return it;
  endfunction

  function int pick_weight();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 16'hFFFF;
      2, 3: return $urandom_range(0, 15);
      default: return $urandom_range(0, 16'hFFFF);
    endcase
  endfunction

  // Holds the sender off until every expected result has come.
  task wait_idle();
    in_valid <= 1'b0;
    while (sb.expected_q.size() > 0) @(posedge clk);
    @(posedge clk);
  endtask

  task write_node_count(int value);
    cfg_valid <= 1'b1;
    cfg_node_count <= CNT_BITS'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.node_count = value;
  endtask

  task send_query(int n);
    if (n > 0 && (n >= MAX_NODES || $urandom_range(0, 4) != 0))
      send_item(make_item(OP_QUERY, $urandom_range(0, n - 1), $urandom_range(0, 1),
                          $urandom_range(0, 1023), $urandom));
    else
      send_item(make_item(OP_QUERY, $urandom_range(n, 1023), $urandom_range(0, 1),
                          $urandom_range(0, 1023), $urandom));
  endtask

  // One random item for a graph of n nodes; labels mostly go to nodes 0..31.
  task send_random(int n);
    int roll;
    int a;
    int b;
    roll = $urandom_range(0, 99);
    if (roll < 25) begin
      a = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 31) : $urandom_range(0, 1023);
      send_item(make_item(OP_LABEL, a, $urandom_range(0, 1), $urandom_range(0, 1023),
                          $urandom));
    end else if (roll < 45 && sb.edges_loaded < 480) begin
      if ($urandom_range(0, 9) < 8) begin
        a = $urandom_range(0, n - 1);
        b = $urandom_range(0, n - 1);
      end else begin
        a = $urandom_range(0, 1023);
        b = $urandom_range(0, 1023);
      end
      send_item(make_item(OP_EDGE, a, $urandom_range(0, 1), b, pick_weight()));
    end else if (roll < 47) begin
      send_item(make_item(OP_RUN, $urandom_range(0, 1023), $urandom_range(0, 1),
                          $urandom_range(0, 1023), $urandom));
    end else begin
      send_query(n);
    end
  endtask

  initial begin
    int sent;
    int n;
    int seg_len;
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_node_count = '0;
    quiet = 1'b0;
    gaps_on = 1'b1;
    stall_left = 0;
    quiet_cycles = 0;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Small four-node graph with two classes, edge extremes and unused nodes.
    write_node_count(4);
    send_item(make_item(OP_LABEL, 0, 0, 0, 0));
    send_item(make_item(OP_LABEL, 1, 1, 1023, 16'hFFFF));
    send_item(make_item(OP_LABEL, 2, 0, 0, 0));
    send_item(make_item(OP_LABEL, 3, 1, 0, 0));
    send_item(make_item(OP_LABEL, 1023, 1, 0, 0));
    send_item(make_item(OP_EDGE, 1, 0, 0, 5));
    send_item(make_item(OP_EDGE, 2, 1, 1, 16'hFFFF));
    send_item(make_item(OP_EDGE, 3, 0, 2, 0));
    send_item(make_item(OP_EDGE, 0, 0, 3, 7));
    send_item(make_item(OP_EDGE, 1023, 0, 1023, 16'hFFFF));
    send_item(make_item(OP_EDGE, 2, 0, 0, 10));
    send_item(make_item(OP_RUN, 0, 0, 0, 0));
    for (int i = 0; i < 4; i++) send_item(make_item(OP_QUERY, i, 0, 0, 0));
    send_item(make_item(OP_QUERY, 4, 0, 0, 0));
    send_item(make_item(OP_QUERY, 1023, 1, 1023, 16'hFFFF));

    // No nodes in use, then counts at and above the node limit.
    wait_idle();
    write_node_count(0);
    send_item(make_item(OP_RUN, 0, 0, 0, 0));
    send_item(make_item(OP_QUERY, 0, 0, 0, 0));
    wait_idle();
    write_node_count(2047);
    send_item(make_item(OP_QUERY, 1023, 0, 0, 0));
    send_item(make_item(OP_QUERY, 3, 0, 0, 0));
    wait_idle();
    write_node_count(1024);
    send_item(make_item(OP_QUERY, 1, 0, 0, 0));
    wait_idle();
    write_node_count(1);

    // Every node a random graph may use gets a label first.
    for (int i = 0; i < 32; i++)
      send_item(make_item(OP_LABEL, i, $urandom_range(0, 1), 0, 0));
    send_item(make_item(OP_RUN, 0, 0, 0, 0));

    // Random segments, each with its own node count and idling mode.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_idle();
      n = ($urandom_range(0, 7) == 0) ? 32 : $urandom_range(1, 16);
      write_node_count(n);
      gaps_on = ($urandom_range(0, 3) != 0);
      seg_len = $urandom_range(30, 90);
      for (int i = 0; i < seg_len; i++) send_random(n);
      sent += seg_len;
    end

    // Last part without idling: fill the edge store past its end, then search.
    wait_idle();
    quiet = 1'b1;
    write_node_count(8);
    while (sb.edges_loaded < MAX_EDGES)
      send_item(make_item(OP_EDGE, $urandom_range(0, 1023), $urandom_range(0, 1),
                          $urandom_range(0, 1023), pick_weight()));
    for (int i = 0; i < 3; i++)
      send_item(make_item(OP_EDGE, $urandom_range(0, 7), 0, $urandom_range(0, 7), 1));
    send_item(make_item(OP_RUN, 0, 0, 0, 0));
    for (int i = 0; i < 8; i++) send_item(make_item(OP_QUERY, i, 0, 0, 0));
    send_item(make_item(OP_QUERY, 1023, 0, 0, 0));

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("** opposite_class_nearest_distance_unit: PASSED **");
    end else begin
      $display("** opposite_class_nearest_distance_unit: FAILED **");
    end
    $finish;
  end

endmodule
